>>> src/fpls_pkg.sv
package fpls_pkg;

  localparam int COORD_BITS = 12;
  localparam int PITCH_BITS = 13;
  localparam int ADDR_BITS  = 24;
  localparam int COLOR_BITS = 8;

  localparam logic [PITCH_BITS-1:0] PITCH_RESET = 13'd320;

  // opcode field
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef struct packed {
    logic                  opcode;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
    logic [COLOR_BITS-1:0] line_color;
  } in_word_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0]  pixel_address;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  last_pixel;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // latch endpoints, set up major axis
    logic step;       // step word accepted
    logic div_start;  // launch minor step divide
    logic finish;     // write minor step from quotient
    logic prime;      // look-ahead accumulators and first address
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_busy;
    logic out_blocked;
    logic line_active;
  } stat_t;

endpackage

>>> src/fixed_point_line_stepper_core.sv
// Fixed-point DDA line stepper.
// Input channel (in_valid / in_stall / in_word): a word with opcode OP_LOAD
// latches both endpoints and the color and sets up the walk; a word with
// opcode OP_STEP asks for the next pixel of the current line.
// Output channel (out_valid / out_stall / out_word): one word per step while
// a line has pixels left: linear address floor(y)*row_pitch + floor(x) mod
// 2^24, the color, and last_pixel on the final one. Steps with no line left
// are taken and give nothing.
// Config: cfg_we / cfg_wdata write row_pitch (reset 320); write only when no
// word is in flight. A write mid-line applies from the next pixel on.
// Timing: a load holds in_stall through the start, wait (bit-serial divider
// forming the minor step) and prime states. Then, while the output is not
// blocked, a step is taken every cycle, its pixel showing on out_word the
// cycle after; the address is tracked incrementally, no multiply per pixel.
// A stalled output word holds; the output register is one deep, so in_stall
// follows out_stall while a word is waiting.
// Reset (rst_n low, synchronous): no line active, output empty, pitch 320.
module fixed_point_line_stepper_core #(
  parameter int FRAC_BITS = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input words
  input  logic                            in_valid,
  output logic                            in_stall,
  input  fpls_pkg::in_word_t              in_word,
  // pixel words
  output logic                            out_valid,
  input  logic                            out_stall,
  output fpls_pkg::out_word_t             out_word,
  // row pitch register
  input  logic                            cfg_we,
  input  logic [fpls_pkg::PITCH_BITS-1:0] cfg_wdata
);

  fpls_pkg::cmd_t  cmd;
  fpls_pkg::stat_t stat;
  logic            in_fire;

  assign in_fire = in_valid && !in_stall;

  // sequencer: load setup, divide, then one step per cycle unless blocked
  fpls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_word.opcode),
    .stat      (stat),
    .in_stall  (in_stall),
    .cmd       (cmd)
  );

  // accumulators, divider, address tracking and the output register
  fpls_dpath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word),
    .stat      (stat)
  );

  // a load starts the setup sequence, so the input is held off next cycle
  a_load_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_word.opcode == fpls_pkg::OP_LOAD) |=> in_stall)
    else $error("input not held off after load");

  // a load never produces a pixel
  a_load_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_word.opcode == fpls_pkg::OP_LOAD) |=> !$rose(out_valid))
    else $error("pixel after load");

  // a step with no line active produces nothing
  a_idle_step_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_word.opcode == fpls_pkg::OP_STEP && !stat.line_active)
      |=> !$rose(out_valid))
    else $error("pixel from step with no line");

  // a rising out_valid comes from a step accepted the cycle before
  a_pixel_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_fire && in_word.opcode == fpls_pkg::OP_STEP))
    else $error("pixel without step");

endmodule

>>> src/fpls_div.sv
module fpls_div #(
  parameter int DVD_W = 23,
  parameter int DSR_W = 13
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DSR_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DSR_W-1:0] dsr_r;
  logic [DSR_W:0]   trial;
  logic [DSR_W:0]   diff;
  logic             ge;

  // restoring divide, one quotient bit per cycle; quotient shifts in behind dividend
  always_comb begin
    trial = {rem_r, dvd_r[DVD_W-1]};
    diff  = trial - {1'b0, dsr_r};
    ge    = trial >= {1'b0, dsr_r};
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    if (start) begin
      cnt_nxt = CNT_W'(DVD_W);
      rem_nxt = '0;
      dvd_nxt = dividend;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      rem_nxt = ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
      dvd_nxt = {dvd_r[DVD_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    if (start) begin
      dsr_r <= divisor;
    end
  end

  assign busy     = cnt_r != '0;
  assign quotient = dvd_r;

endmodule

>>> src/fpls_ctrl.sv
module fpls_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_opcode,
  input  fpls_pkg::stat_t stat,
  output logic           in_stall,
  output fpls_pkg::cmd_t cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_START = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_PRIME = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       fire;

  always_comb begin
    in_stall  = (state_r != S_IDLE) || stat.out_blocked;
    fire      = in_valid && !in_stall;
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (fire) begin
          if (in_opcode == fpls_pkg::OP_LOAD) begin
            cmd.load  = 1'b1;
            state_nxt = S_START;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      S_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_WAIT;
      end
      S_WAIT: begin
        if (!stat.div_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = S_PRIME;
        end
      end
      S_PRIME: begin
        cmd.prime = 1'b1;
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> src/fpls_dpath.sv
module fpls_dpath #(
  parameter int FRAC_BITS = 10
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  fpls_pkg::in_word_t                   in_word,
  input  fpls_pkg::cmd_t                       cmd,
  input  logic                                 cfg_we,
  input  logic [fpls_pkg::PITCH_BITS-1:0]      cfg_wdata,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output fpls_pkg::out_word_t                  out_word,
  output fpls_pkg::stat_t                      stat
);

  localparam int C     = fpls_pkg::COORD_BITS;
  localparam int L     = C + 1;
  localparam int A     = C + FRAC_BITS + 2;
  localparam int DVD_W = C + 1 + FRAC_BITS;
  localparam int PW    = fpls_pkg::PITCH_BITS;
  localparam int AW    = fpls_pkg::ADDR_BITS;
  localparam int PROD_W = C + PW;

  localparam logic [A-1:0] ONE_PIX = A'(1) << FRAC_BITS;
  localparam logic [A-1:0] NEG_PIX = A'(0) - ONE_PIX;

  // floor delta codes (low two bits of the integer-part difference)
  localparam logic [1:0] DLT_UP = 2'b01;
  localparam logic [1:0] DLT_DN = 2'b11;

  // load setup
  logic [C:0]   dx, dy, ndx, ndy;
  logic [C-1:0] adx, ady, major_mag, minor_mag;
  logic         x_major, major_neg, minor_neg;
  logic [L-1:0] len;
  logic [PROD_W-1:0] row_prod;

  // state
  logic [PW-1:0]  pitch_r;
  logic [A-1:0]   x_acc_r, y_acc_r, x_next_r, y_next_r;
  logic [A-1:0]   x_step_r, y_step_r;
  logic [L-1:0]   pix_left_r;
  logic [fpls_pkg::COLOR_BITS-1:0] color_r;
  logic           x_major_r, minor_neg_r;
  logic [C-1:0]   minor_mag_r;
  logic [L-1:0]   len_r;
  logic [C-1:0]   col_r;
  logic [AW-1:0]  row_prod_r;
  logic [AW-1:0]  addr_r;
  logic           out_valid_r;
  fpls_pkg::out_word_t out_word_r;

  // divider
  logic [L-1:0]     mag_p1;
  logic [DVD_W-1:0] dividend, quotient;
  logic             div_busy;
  logic [A-1:0]     q_ext, minor_val;

  // stepping
  logic          emit;
  logic [1:0]    dfx, dfy;
  logic [AW-1:0] x_term, y_term, pitch_ext;

  // pitch write
  logic [AW-1:0] row_ext, col_ext, cfg_addr;

  always_comb begin
    dx  = {1'b0, in_word.x_end} - {1'b0, in_word.x_start};
    dy  = {1'b0, in_word.y_end} - {1'b0, in_word.y_start};
    ndx = -dx;
    ndy = -dy;
    adx = dx[C] ? ndx[C-1:0] : dx[C-1:0];
    ady = dy[C] ? ndy[C-1:0] : dy[C-1:0];
    x_major   = adx >= ady;
    major_mag = x_major ? adx : ady;
    minor_mag = x_major ? ady : adx;
    major_neg = x_major ? dx[C] : dy[C];
    minor_neg = x_major ? dy[C] : dx[C];
    len       = {1'b0, major_mag} + L'(1);
    row_prod  = PROD_W'(in_word.y_start) * PROD_W'(pitch_r);
  end

  always_comb begin
    mag_p1    = {1'b0, minor_mag_r} + L'(1);
    dividend  = {mag_p1, {FRAC_BITS{1'b0}}};
    q_ext     = {{(A - DVD_W){1'b0}}, quotient};
    minor_val = minor_neg_r ? (A'(0) - q_ext) : q_ext;
  end

  fpls_div #(
    .DVD_W (DVD_W),
    .DSR_W (L)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (len_r),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // per-pixel address update: integer parts move by at most one per step
  always_comb begin
    emit      = cmd.step && (pix_left_r != '0);
    dfx       = x_next_r[FRAC_BITS+1:FRAC_BITS] - x_acc_r[FRAC_BITS+1:FRAC_BITS];
    dfy       = y_next_r[FRAC_BITS+1:FRAC_BITS] - y_acc_r[FRAC_BITS+1:FRAC_BITS];
    pitch_ext = AW'(pitch_r);
    unique case (dfx)
      DLT_UP:  x_term = AW'(1);
      DLT_DN:  x_term = '1;
      default: x_term = '0;
    endcase
    unique case (dfy)
      DLT_UP:  y_term = pitch_ext;
      DLT_DN:  y_term = AW'(0) - pitch_ext;
      default: y_term = '0;
    endcase
  end

  // address of the next pixel under a newly written pitch, signed floors
  always_comb begin
    row_ext  = AW'($signed(y_acc_r[A-1:FRAC_BITS]));
    col_ext  = AW'($signed(x_acc_r[A-1:FRAC_BITS]));
    cfg_addr = row_ext * AW'(cfg_wdata) + col_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_r     <= fpls_pkg::PITCH_RESET;
      pix_left_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        pitch_r <= cfg_wdata;
      end
      if (cmd.load) begin
        pix_left_r <= len;
      end else if (emit) begin
        pix_left_r <= pix_left_r - L'(1);
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_acc_r     <= A'(in_word.x_start) << FRAC_BITS;
      y_acc_r     <= A'(in_word.y_start) << FRAC_BITS;
      x_major_r   <= x_major;
      minor_neg_r <= minor_neg;
      minor_mag_r <= minor_mag;
      len_r       <= len;
      color_r     <= in_word.line_color;
      col_r       <= in_word.x_start;
      row_prod_r  <= row_prod[AW-1:0];
      if (x_major) begin
        x_step_r <= major_neg ? NEG_PIX : ONE_PIX;
      end else begin
        y_step_r <= major_neg ? NEG_PIX : ONE_PIX;
      end
    end else if (cmd.finish) begin
      if (x_major_r) begin
        y_step_r <= minor_val;
      end else begin
        x_step_r <= minor_val;
      end
    end else if (cmd.prime) begin
      x_next_r <= x_acc_r + x_step_r;
      y_next_r <= y_acc_r + y_step_r;
      addr_r   <= row_prod_r + AW'(col_r);
    end else if (emit) begin
      x_acc_r  <= x_next_r;
      y_acc_r  <= y_next_r;
      x_next_r <= x_next_r + x_step_r;
      y_next_r <= y_next_r + y_step_r;
      addr_r   <= addr_r + y_term + x_term;
    end else if (cfg_we) begin
      // pitch write mid-line: the rest of the line uses the new pitch
      addr_r   <= cfg_addr;
    end
    if (emit) begin
      out_word_r.pixel_address <= addr_r;
      out_word_r.pixel_color   <= color_r;
      out_word_r.last_pixel    <= pix_left_r == L'(1);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_word         = out_word_r;
  assign stat.div_busy    = div_busy;
  assign stat.out_blocked = out_valid_r && out_stall;
  assign stat.line_active = pix_left_r != '0;

endmodule

>>> bench/fixed_point_line_stepper_core_check.sv
module fixed_point_line_stepper_core_check #(
  parameter int FRAC_BITS = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  fpls_pkg::in_word_t              in_word,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  fpls_pkg::out_word_t             out_word,
  input  logic                            cfg_we,
  input  logic [fpls_pkg::PITCH_BITS-1:0] cfg_wdata,
  output int                              fail_count,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_BITS = fpls_pkg::COORD_BITS;
  localparam int COLOR_BITS = fpls_pkg::COLOR_BITS;
  localparam int PITCH_BITS = fpls_pkg::PITCH_BITS;
  localparam int ADDR_BITS  = fpls_pkg::ADDR_BITS;

  localparam int ACC_BITS = COORD_BITS + FRAC_BITS + 2;
  typedef logic [ACC_BITS-1:0] acc_t;
  localparam acc_t ONE_PX = acc_t'(1) << FRAC_BITS;

  // line walker state, fixed point with FRAC_BITS fraction
  acc_t                  x_pos;
  acc_t                  y_pos;
  acc_t                  x_inc;
  acc_t                  y_inc;
  logic [COORD_BITS:0]   pixels_left;
  logic [COLOR_BITS-1:0] held_color;
  logic [PITCH_BITS-1:0] row_pitch;

  fpls_pkg::out_word_t pixel_queue[$];
  int                  fails = 0;

  // (|d|+1) << F over len, truncated toward zero, sign of d
  function automatic acc_t minor_increment(input longint delta, input longint len);
    longint mag;
    longint q;
    mag = (delta < 0) ? -delta : delta;
    q   = ((mag + 1) << FRAC_BITS) / len;
    if (delta < 0) q = -q;
    return acc_t'(q);
  endfunction

  task automatic take_word(input fpls_pkg::in_word_t w);
    longint              dx;
    longint              dy;
    longint              adx;
    longint              ady;
    longint              len;
    longint              row;
    longint              col;
    longint              addr;
    fpls_pkg::out_word_t px;
    if (w.opcode == fpls_pkg::OP_LOAD) begin
      dx  = longint'(w.x_end) - longint'(w.x_start);
      dy  = longint'(w.y_end) - longint'(w.y_start);
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      x_pos = acc_t'(w.x_start) << FRAC_BITS;
      y_pos = acc_t'(w.y_start) << FRAC_BITS;
      if (adx >= ady) begin
        len   = adx + 1;
        x_inc = (dx < 0) ? acc_t'(0) - ONE_PX : ONE_PX;
        y_inc = minor_increment(dy, len);
      end else begin
        len   = ady + 1;
        y_inc = (dy < 0) ? acc_t'(0) - ONE_PX : ONE_PX;
        x_inc = minor_increment(dx, len);
      end
      pixels_left = (COORD_BITS+1)'(len);
      held_color  = w.line_color;
    end else if (pixels_left != 0) begin
      // arithmetic shift of the signed accumulator is floor()
      row  = longint'($signed(y_pos)) >>> FRAC_BITS;
      col  = longint'($signed(x_pos)) >>> FRAC_BITS;
      addr = row * longint'(row_pitch) + col;
      px.pixel_address = ADDR_BITS'(addr);
      px.pixel_color   = held_color;
      px.last_pixel    = (pixels_left == 1);
      pixel_queue.push_back(px);
      x_pos       = x_pos + x_inc;
      y_pos       = y_pos + y_inc;
      pixels_left = pixels_left - 1'b1;
    end
  endtask

  task automatic check_pixel(input fpls_pkg::out_word_t got);
    fpls_pkg::out_word_t want;
    if (pixel_queue.size() == 0) begin
      $error("pixel word with none expected: pixel_address %0h", got.pixel_address);
      fails++;
      return;
    end
    want = pixel_queue.pop_front();
    if (got.pixel_address !== want.pixel_address) begin
      $error("pixel_address: expected %0h, actual %0h",
             want.pixel_address, got.pixel_address);
      fails++;
    end
    if (got.pixel_color !== want.pixel_color) begin
      $error("pixel_color: expected %0h, actual %0h", want.pixel_color, got.pixel_color);
      fails++;
    end
    if (got.last_pixel !== want.last_pixel) begin
      $error("last_pixel: expected %0b, actual %0b", want.last_pixel, got.last_pixel);
      fails++;
    end
  endtask

  // output first: a pixel leaving now never comes from a word taken now
  always @(posedge clk) begin
    if (!rst_n) begin
      x_pos       = '0;
      y_pos       = '0;
      x_inc       = '0;
      y_inc       = '0;
      pixels_left = '0;
      held_color  = '0;
      row_pitch   = fpls_pkg::PITCH_RESET;
      pixel_queue.delete();
    end else begin
      if (out_valid && !out_stall) check_pixel(out_word);
      if (cfg_we) row_pitch = cfg_wdata;
      if (in_valid && !in_stall) take_word(in_word);
    end
    pending    <= pixel_queue.size();
    fail_count <= fails;
  end

endmodule

>>> bench/fixed_point_line_stepper_core_test.sv
module fixed_point_line_stepper_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_BITS = fpls_pkg::COORD_BITS;
  localparam int COLOR_BITS = fpls_pkg::COLOR_BITS;
  localparam int PITCH_BITS = fpls_pkg::PITCH_BITS;

  // no-handshake cycles before giving up; worst legal gap is a load's setup
  // plus a sender gap and a receiver stall, or a settle pause
  localparam int WATCHDOG_LIMIT = 2000;
  // extra cycles after the last pixel before a pitch write or the verdict;
  // covers a load still busy in the divider
  localparam int SETTLE_CYCLES  = 40;
  localparam int MAX_COORD      = (1 << COORD_BITS) - 1;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  fpls_pkg::in_word_t    in_word   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  fpls_pkg::out_word_t   out_word;
  logic                  cfg_we    = 1'b0;
  logic [PITCH_BITS-1:0] cfg_wdata = '0;

  int fail_count;
  int pending;

  // knobs for idling; quiet turns all idling off for the tail of the run
  bit quiet         = 1'b0;
  int send_idle_pct = 10;
  int stall_pct     = 5;

  int words_sent = 0;   // loads plus steps that make a pixel
  int line_left  = 0;   // pixels still owed by the current line
  int idle_cycles = 0;

  always #4 clk = ~clk;

  fixed_point_line_stepper_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  fixed_point_line_stepper_core_check u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Receiver side: random stall bursts, none once quiet.
  initial begin : out_backpressure
    int span;
    forever begin
      @(posedge clk);
      if (!quiet && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        span = $urandom_range(1, 18);
        out_stall <= 1'b1;
        repeat (span) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: any accepted word on either channel resets the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Present a word and hold it until taken. An optional gap goes first, so
  // in_valid is never lowered and raised in the same step.
  task automatic send_word(input fpls_pkg::in_word_t w);
    int gap;
    if (!quiet && send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_load(input int xs, input int ys, input int xe, input int ye,
                           input int color);
    fpls_pkg::in_word_t w;
    int                 adx;
    int                 ady;
    w.opcode     = fpls_pkg::OP_LOAD;
    w.x_start    = COORD_BITS'(xs);
    w.y_start    = COORD_BITS'(ys);
    w.x_end      = COORD_BITS'(xe);
    w.y_end      = COORD_BITS'(ye);
    w.line_color = COLOR_BITS'(color);
    send_word(w);
    // only used to shape the step count, not for checking
    adx = (xe > xs) ? xe - xs : xs - xe;
    ady = (ye > ys) ? ye - ys : ys - ye;
    line_left = ((adx > ady) ? adx : ady) + 1;
    words_sent++;
  endtask

  // step words carry random junk in the unused fields
  task automatic send_step();
    fpls_pkg::in_word_t w;
    w.opcode     = fpls_pkg::OP_STEP;
    w.x_start    = COORD_BITS'($urandom);
    w.y_start    = COORD_BITS'($urandom);
    w.x_end      = COORD_BITS'($urandom);
    w.y_end      = COORD_BITS'($urandom);
    w.line_color = COLOR_BITS'($urandom);
    send_word(w);
    if (line_left > 0) begin
      line_left--;
      words_sent++;
    end
  endtask

  task automatic walk(input int n);
    repeat (n) send_step();
  endtask

  // Hold off the sender until every pixel is out, then let a pending
  // divide finish.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_pitch(input int pitch);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= PITCH_BITS'(pitch);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // endpoint within span of c, mirrored back if it falls off the grid
  function automatic int near(input int c, input int span);
    int d;
    int e;
    d = int'($urandom_range(0, 2 * span)) - span;
    e = c + d;
    if (e < 0 || e > MAX_COORD) e = c - d;
    return e;
  endfunction

  // Mostly complete lines with random content; some cut short, overrun,
  // replaced right away, or plain steps with no line.
  task automatic random_lines(input int n);
    int goal;
    int kind;
    int pick;
    int span;
    int steps;
    int xs;
    int ys;
    goal = words_sent + n;
    while (words_sent < goal) begin
      kind = $urandom_range(0, 99);
      xs   = $urandom_range(0, MAX_COORD);
      ys   = $urandom_range(0, MAX_COORD);
      if (kind < 80) begin
        span = ($urandom_range(0, 19) == 0) ? 300 : 24;
        send_load(xs, ys, near(xs, span), near(ys, span), $urandom_range(0, 255));
        pick = $urandom_range(0, 19);
        if (pick == 0)      steps = $urandom_range(0, line_left);
        else if (pick == 1) steps = line_left + $urandom_range(1, 3);
        else                steps = line_left;
        walk(steps);
      end else if (kind < 88) begin
        // long line anywhere on the grid, only the start walked
        send_load(xs, ys, $urandom_range(0, MAX_COORD), $urandom_range(0, MAX_COORD),
                  $urandom_range(0, 255));
        walk($urandom_range(0, 40));
      end else if (kind < 95) begin
        walk($urandom_range(1, 3));
      end else if (kind < 99) begin
        send_load(xs, ys, near(xs, 24), near(ys, 24), $urandom_range(0, 255));
        send_load(ys, xs, near(ys, 24), near(xs, 24), $urandom_range(0, 255));
        walk(line_left);
      end else begin
        settle();
      end
    end
  endtask

  initial begin : stimulus
    int pitch_set [5];
    int idle_set  [5];
    int stall_set [5];
    pitch_set = '{1, 4096, 8191, 0, 0};
    idle_set  = '{10, 0, 25, 5, 15};
    stall_set = '{5, 10, 0, 20, 3};
    pitch_set[4] = $urandom_range(1, 4096);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed, at the reset pitch ---
    send_step();                          // nothing loaded yet
    send_load(0, 0, 0, 0, 8'h00);         // single pixel, then a dead step
    walk(2);
    send_load(5, 3, 9, 3, 8'hff);         // flat, rightward
    walk(5);
    send_load(9, 3, 5, 3, 8'h5a);         // flat, leftward
    walk(5);
    send_load(7, 10, 7, 14, 8'h01);       // vertical; zero delta still drifts x
    walk(5);
    send_load(20, 0, 17, 6, 8'h80);       // steep, minor axis moving left
    walk(7);
    send_load(0, 5, 6, 0, 8'h33);         // row overshoots to -1 near the end
    walk(7);
    send_load(3, 0, 0, 8, 8'hcc);         // column overshoots to -1
    walk(9);
    send_load(MAX_COORD, MAX_COORD, MAX_COORD - 5, MAX_COORD - 2, 8'hfe);
    walk(2);                              // cut off by the next load
    send_load(MAX_COORD, 0, MAX_COORD - 7, 7, 8'h7f);
    walk(8);
    send_load(0, MAX_COORD, 3, MAX_COORD, 8'h0f);
    walk(4);

    // --- random phases, one pitch each ---
    for (int p = 0; p < 5; p++) begin
      set_pitch(pitch_set[p]);
      send_idle_pct = idle_set[p];
      stall_pct     = stall_set[p];
      if (pitch_set[p] == 8191) begin
        // corner to corner sweeps, start only; address wraps mod 2^24
        send_load(0, MAX_COORD, MAX_COORD, 0, 8'ha5);
        walk(64);
        send_load(MAX_COORD, 0, 0, MAX_COORD, 8'h3c);
        walk(64);
      end
      random_lines(270);
    end

    // --- tail: back to the reset pitch, no idling on either side ---
    set_pitch(int'(fpls_pkg::PITCH_RESET));
    quiet         = 1'b1;
    send_idle_pct = 0;
    stall_pct     = 0;
    random_lines(150);

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
